[design/lcar_pkg.sv]
// shared constants and types for the load cell converter reader
// used by every module of the block; no dependencies
package lcar_pkg;

    localparam int DATA_BITS  = 24;
    localparam int WINDOW_MAX = 16;
    localparam int IDX_W      = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int LEN_W      = $clog2(WINDOW_MAX + 1);
    localparam int SUM_W      = DATA_BITS + IDX_W + 1;
    localparam int NET_W      = DATA_BITS + 1;
    localparam int SCALE_W    = 32;
    localparam int PROD_W     = NET_W + SCALE_W;
    localparam int WEIGHT_W   = 32;
    localparam int FRAC_BITS  = 24;
    localparam int HALF_W     = 10;
    localparam int WIN_W      = 5;
    localparam int TICK_W     = 11;
    localparam int BIT_W      = 5;

    typedef enum logic [1:0] {
        REG_HALF_PERIOD = 2'd0,
        REG_WINDOW_LEN  = 2'd1,
        REG_TARE        = 2'd2,
        REG_SCALE       = 2'd3
    } cfg_reg_t;

    // what one tick of the serial sequencer produced
    typedef struct packed {
        logic                 sck;
        logic                 done;
        logic [DATA_BITS-1:0] raw;
    } step_t;

    // requests from the controller to the sample ring
    typedef struct packed {
        logic                 wr_en;
        logic [DATA_BITS-1:0] wr_data;
        logic [IDX_W-1:0]     rd_addr;
    } ring_req_t;

endpackage

[design/lcar_serial.sv]
// serial clock sequencer: waits for data ready, bit-bangs 24 pulses plus one
// extra, shifts in the data pin; depends on lcar_pkg
module lcar_serial (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          step_en,
    input  logic                          dout,
    input  logic [lcar_pkg::HALF_W-1:0]   half_period,
    output lcar_pkg::step_t               step
);
    import lcar_pkg::*;

    typedef enum logic [2:0] {
        PH_WAIT,
        PH_FIRST_LOW,
        PH_HIGH,
        PH_READ,
        PH_END_HIGH,
        PH_END_LOW
    } phase_t;

    localparam logic [TICK_W-1:0] TICK_MAX = {TICK_W{1'b1}};

    phase_t                phase_reg, phase_next;
    logic [TICK_W-1:0]     tick_reg, tick_next, tick_inc;
    logic [BIT_W-1:0]      bit_reg, bit_next, bit_inc;
    logic [DATA_BITS-1:0]  shift_reg, shift_next;
    logic                  level_reg, level_next;
    logic                  edge_hit;
    logic                  done;

    always_comb
    begin
        tick_inc   = (tick_reg < TICK_MAX) ? tick_reg + TICK_W'(1) : tick_reg;
        edge_hit   = tick_inc > TICK_W'(half_period);
        bit_inc    = bit_reg + BIT_W'(1);
        phase_next = phase_reg;
        tick_next  = tick_inc;
        bit_next   = bit_reg;
        shift_next = shift_reg;
        level_next = level_reg;
        done       = 1'b0;
        case (phase_reg)
            PH_WAIT:
            begin
                if (!dout)
                begin
                    phase_next = PH_FIRST_LOW;
                    tick_next  = '0;
                end
            end
            PH_FIRST_LOW:
            begin
                if (edge_hit)
                begin
                    level_next = 1'b0;
                    phase_next = PH_HIGH;
                    tick_next  = '0;
                end
            end
            PH_HIGH:
            begin
                if (edge_hit)
                begin
                    level_next = 1'b1;
                    phase_next = PH_READ;
                    tick_next  = '0;
                end
            end
            PH_READ:
            begin
                if (edge_hit)
                begin
                    shift_next = {shift_reg[DATA_BITS-2:0], dout};
                    level_next = 1'b0;
                    tick_next  = '0;
                    if (bit_inc >= BIT_W'(DATA_BITS))
                    begin
                        bit_next   = '0;
                        phase_next = PH_END_HIGH;
                    end
                    else
                    begin
                        bit_next   = bit_inc;
                        phase_next = PH_HIGH;
                    end
                end
            end
            PH_END_HIGH:
            begin
                if (edge_hit)
                begin
                    level_next = 1'b1;
                    phase_next = PH_END_LOW;
                    tick_next  = '0;
                end
            end
            PH_END_LOW:
            begin
                // counter is left running here on purpose
                if (edge_hit)
                begin
                    level_next = 1'b0;
                    phase_next = PH_WAIT;
                    shift_next = '0;
                    done       = 1'b1;
                end
            end
            default:
            begin
                phase_next = PH_WAIT;
            end
        endcase
    end

    assign step.sck  = level_next;
    assign step.done = done;
    assign step.raw  = shift_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_WAIT;
            tick_reg  <= '0;
            bit_reg   <= '0;
            shift_reg <= '0;
            level_reg <= 1'b0;
        end
        else if (step_en)
        begin
            phase_reg <= phase_next;
            tick_reg  <= tick_next;
            bit_reg   <= bit_next;
            shift_reg <= shift_next;
            level_reg <= level_next;
        end
    end

endmodule

[design/lcar_ring.sv]
// sample ring: synchronous memory of window entries with per-entry valid bits
// and the write index; depends on lcar_pkg
module lcar_ring (
    input  logic                           clk,
    input  logic                           rst_n,
    input  lcar_pkg::ring_req_t            req,
    input  logic [lcar_pkg::LEN_W-1:0]     len,
    output logic [lcar_pkg::DATA_BITS-1:0] rd_data
);
    import lcar_pkg::*;

    logic [DATA_BITS-1:0]  mem [WINDOW_MAX];
    logic [WINDOW_MAX-1:0] valid_reg;
    logic [IDX_W-1:0]      index_reg;
    logic [LEN_W-1:0]      index_inc;
    logic [DATA_BITS-1:0]  rd_q_reg;
    logic                  rd_valid_reg;

    assign index_inc = LEN_W'(index_reg) + LEN_W'(1);

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[index_reg] <= req.wr_data;
        end
        rd_q_reg <= mem[req.rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            index_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= valid_reg[req.rd_addr];
            if (req.wr_en)
            begin
                valid_reg[index_reg] <= 1'b1;
                index_reg <= (index_inc >= len) ? '0 : IDX_W'(index_inc);
            end
        end
    end

    // entries never written read as zero
    assign rd_data = rd_valid_reg ? rd_q_reg : '0;

endmodule

[design/lcar_div.sv]
// restoring divider, one quotient bit per cycle, for the window mean
// depends on lcar_pkg
module lcar_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [lcar_pkg::SUM_W-1:0] dividend,
    input  logic [lcar_pkg::LEN_W-1:0] divisor,
    output logic                       done,
    output logic [lcar_pkg::SUM_W-1:0] quotient
);
    import lcar_pkg::*;

    localparam int CNT_W = $clog2(SUM_W);

    logic              busy_reg;
    logic              done_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [LEN_W-1:0]  rem_reg;
    logic [LEN_W-1:0]  div_reg;
    logic [SUM_W-1:0]  quo_reg;
    logic [LEN_W:0]    trial;
    logic              fits;
    logic [LEN_W-1:0]  rem_next;

    always_comb
    begin
        trial    = {rem_reg, quo_reg[SUM_W-1]};
        fits     = trial >= {1'b0, div_reg};
        rem_next = fits ? LEN_W'(trial - {1'b0, div_reg}) : trial[LEN_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            rem_reg  <= '0;
            div_reg  <= '0;
            quo_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                rem_reg  <= '0;
                div_reg  <= divisor;
                quo_reg  <= dividend;
            end
            else if (busy_reg)
            begin
                rem_reg <= rem_next;
                quo_reg <= {quo_reg[SUM_W-2:0], fits};
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(SUM_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

[design/load_cell_adc_reader.sv]
// load cell converter reader: one tick in, one result out
// a tick without a finished conversion: result registered in the cycle after the transfer
// a tick that ends a conversion: ring read sweep over the effective window length
// (1 to 16), drain, 29-step mean divider, multiply, truncate and saturate
// next tick is taken once the previous result is done; reset puts the sequencer
// in its wait phase, makes the ring read as zero and loads register defaults
module load_cell_adc_reader (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_addr,
    input  logic [31:0]  cfg_wdata,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [0] dout, [7:1] zero
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [111:0] m_tdata,   // [0] sck, [24:1] raw_sample, [48:25] average,
                                    // [73:49] net_count, [105:74] weight, rest zero
    output logic         m_tuser    // [0] sample_valid
);
    import lcar_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SUM,
        S_DRAIN,
        S_DIV_GO,
        S_DIV_WAIT,
        S_MUL,
        S_OUT
    } state_t;

    state_t                      state_reg;
    logic [HALF_W-1:0]           half_reg;
    logic [WIN_W-1:0]            win_reg;
    logic signed [DATA_BITS-1:0] tare_reg;
    logic signed [SCALE_W-1:0]   scale_reg;

    logic [IDX_W-1:0]            rd_cnt_reg;
    logic                        rd_pend_reg;
    logic signed [SUM_W-1:0]     sum_reg;
    logic signed [NET_W-1:0]     net_reg;
    logic signed [DATA_BITS-1:0] avg_reg;
    logic signed [PROD_W-1:0]    prod_reg;
    logic                        sck_hold_reg;
    logic [DATA_BITS-1:0]        raw_hold_reg;

    logic                        out_valid_reg;
    logic                        out_sck_reg;
    logic                        out_flag_reg;
    logic [DATA_BITS-1:0]        out_raw_reg;
    logic [DATA_BITS-1:0]        out_avg_reg;
    logic [NET_W-1:0]            out_net_reg;
    logic [WEIGHT_W-1:0]         out_w_reg;

    step_t                       step;
    ring_req_t                   ring_req;
    logic [DATA_BITS-1:0]        ring_rd;
    logic [LEN_W-1:0]            len;
    logic                        accept;
    logic                        slot_free;
    logic                        div_done;
    logic [SUM_W-1:0]            quo;
    logic [SUM_W-1:0]            sum_mag;
    logic signed [DATA_BITS-1:0] avg_c;
    logic signed [NET_W-1:0]     net_c;
    logic signed [PROD_W-1:0]    prod_bias;
    logic signed [PROD_W-FRAC_BITS-1:0] w_wide;
    logic [WEIGHT_W-1:0]         w_sat;

    // window length clamped to 1..WINDOW_MAX
    always_comb
    begin
        if (win_reg == '0)
            len = LEN_W'(1);
        else if (int'(win_reg) > WINDOW_MAX)
            len = LEN_W'(WINDOW_MAX);
        else
            len = LEN_W'(win_reg);
    end

    assign slot_free = !out_valid_reg || m_tready;
    assign s_tready  = (state_reg == S_IDLE) && slot_free;
    assign accept    = s_tvalid && s_tready;

    lcar_serial u_serial (
        .clk         (clk),
        .rst_n       (rst_n),
        .step_en     (accept),
        .dout        (s_tdata[0]),
        .half_period (half_reg),
        .step        (step)
    );

    assign ring_req.wr_en   = accept && step.done;
    assign ring_req.wr_data = step.raw;
    assign ring_req.rd_addr = rd_cnt_reg;

    lcar_ring u_ring (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (ring_req),
        .len     (len),
        .rd_data (ring_rd)
    );

    assign sum_mag = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);

    lcar_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (state_reg == S_DIV_GO),
        .dividend (sum_mag),
        .divisor  (len),
        .done     (div_done),
        .quotient (quo)
    );

    always_comb
    begin
        // mean truncates toward zero, so the sign goes back on the magnitude
        avg_c = DATA_BITS'(sum_reg[SUM_W-1] ? (SUM_W'(0) - quo) : quo);
        net_c = NET_W'(avg_c) - NET_W'(tare_reg);
        // bias negative products so the shift truncates toward zero
        prod_bias = prod_reg[PROD_W-1]
                  ? prod_reg + PROD_W'((64'd1 << FRAC_BITS) - 64'd1)
                  : prod_reg;
        w_wide = prod_bias[PROD_W-1:FRAC_BITS];
        if (w_wide[PROD_W-FRAC_BITS-1] != w_wide[WEIGHT_W-1])
            w_sat = w_wide[PROD_W-FRAC_BITS-1] ? {1'b1, {(WEIGHT_W-1){1'b0}}}
                                               : {1'b0, {(WEIGHT_W-1){1'b1}}};
        else
            w_sat = w_wide[WEIGHT_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            half_reg      <= HALF_W'(10);
            win_reg       <= WIN_W'(3);
            tare_reg      <= '0;
            scale_reg     <= SCALE_W'(12451);
            rd_cnt_reg    <= '0;
            rd_pend_reg   <= 1'b0;
            sum_reg       <= '0;
            net_reg       <= '0;
            avg_reg       <= '0;
            prod_reg      <= '0;
            sck_hold_reg  <= 1'b0;
            raw_hold_reg  <= '0;
            out_valid_reg <= 1'b0;
            out_sck_reg   <= 1'b0;
            out_flag_reg  <= 1'b0;
            out_raw_reg   <= '0;
            out_avg_reg   <= '0;
            out_net_reg   <= '0;
            out_w_reg     <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_reg_t'(cfg_addr))
                    REG_HALF_PERIOD: half_reg  <= cfg_wdata[HALF_W-1:0];
                    REG_WINDOW_LEN:  win_reg   <= cfg_wdata[WIN_W-1:0];
                    REG_TARE:        tare_reg  <= cfg_wdata[DATA_BITS-1:0];
                    REG_SCALE:       scale_reg <= cfg_wdata[SCALE_W-1:0];
                    default:         ;
                endcase
            end

            if (out_valid_reg && m_tready)
                out_valid_reg <= 1'b0;

            rd_pend_reg <= (state_reg == S_SUM);
            if (rd_pend_reg)
                sum_reg <= sum_reg + SUM_W'(signed'(ring_rd));

            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        if (step.done)
                        begin
                            sck_hold_reg <= step.sck;
                            raw_hold_reg <= step.raw;
                            sum_reg      <= '0;
                            rd_cnt_reg   <= '0;
                            state_reg    <= S_SUM;
                        end
                        else
                        begin
                            out_valid_reg <= 1'b1;
                            out_sck_reg   <= step.sck;
                            out_flag_reg  <= 1'b0;
                            out_raw_reg   <= '0;
                            out_avg_reg   <= '0;
                            out_net_reg   <= '0;
                            out_w_reg     <= '0;
                        end
                    end
                end
                S_SUM:
                begin
                    // one ring read per cycle over entries 0 .. len-1
                    if (LEN_W'(rd_cnt_reg) == len - LEN_W'(1))
                    begin
                        rd_cnt_reg <= '0;
                        state_reg  <= S_DRAIN;
                    end
                    else
                    begin
                        rd_cnt_reg <= rd_cnt_reg + IDX_W'(1);
                    end
                end
                S_DRAIN:
                begin
                    state_reg <= S_DIV_GO;
                end
                S_DIV_GO:
                begin
                    state_reg <= S_DIV_WAIT;
                end
                S_DIV_WAIT:
                begin
                    if (div_done)
                    begin
                        avg_reg   <= avg_c;
                        net_reg   <= net_c;
                        state_reg <= S_MUL;
                    end
                end
                S_MUL:
                begin
                    prod_reg  <= PROD_W'(net_reg) * PROD_W'(scale_reg);
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (slot_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_sck_reg   <= sck_hold_reg;
                        out_flag_reg  <= 1'b1;
                        out_raw_reg   <= raw_hold_reg;
                        out_avg_reg   <= avg_reg;
                        out_net_reg   <= net_reg;
                        out_w_reg     <= w_sat;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_flag_reg;
    assign m_tdata  = {6'd0, out_w_reg, out_net_reg, out_avg_reg, out_raw_reg, out_sck_reg};

endmodule

[sim/tb_load_cell_adc_reader.sv]
// testbench for load_cell_adc_reader: feeds converter ticks with random pauses on both
// stream sides and checks every result against a tick-level model of the serial reader
// depends on lcar_pkg and the load_cell_adc_reader rtl
module tb_load_cell_adc_reader;
    import lcar_pkg::*;

    localparam int     SETTLE_CYCLES  = 64;    // room for the longest tick, with a window of 16
    localparam int     STALL_LIMIT    = 1000;
    localparam int     EDGES_PER_READ = 51;    // first low, 24 high/low pairs, end pulse
    localparam longint GRAMS_MAX      = 64'sd2147483647;
    localparam longint GRAMS_MIN      = -64'sd2147483648;

    typedef enum logic [2:0] {
        SEQ_WAIT,
        SEQ_FIRST_LOW,
        SEQ_HIGH,
        SEQ_READ,
        SEQ_END_HIGH,
        SEQ_END_LOW
    } seq_phase_t;

    typedef struct packed {
        logic                 sck;
        logic                 valid;
        logic [DATA_BITS-1:0] raw;
        logic [DATA_BITS-1:0] avg;
        logic [NET_W-1:0]     net_cnt;
        logic [WEIGHT_W-1:0]  weight;
    } reading_t;

    logic         clk;
    logic         rst_n     = 1'b0;
    logic         cfg_we    = 1'b0;
    logic [1:0]   cfg_addr  = '0;
    logic [31:0]  cfg_wdata = '0;
    logic         s_tvalid  = 1'b0;
    logic         s_tready;
    logic [7:0]   s_tdata   = '0;   // [0] dout, [7:1] zero
    logic         m_tvalid;
    logic         m_tready  = 1'b0;
    logic [111:0] m_tdata;          // [0] sck, [24:1] raw_sample, [48:25] average,
                                    // [73:49] net_count, [105:74] weight, rest zero
    logic         m_tuser;          // [0] sample_valid

    // model copy of the registers and the sequencer
    logic [HALF_W-1:0]           half_period = 10'd10;
    logic [WIN_W-1:0]            window_len  = 5'd3;
    logic signed [DATA_BITS-1:0] tare        = '0;
    logic signed [SCALE_W-1:0]   scale       = 32'sd12451;
    seq_phase_t                  phase       = SEQ_WAIT;
    logic [TICK_W-1:0]           tick_cnt    = '0;
    logic [BIT_W-1:0]            bits_in     = '0;
    logic [DATA_BITS-1:0]        shift_reg   = '0;
    logic                        sck_level   = 1'b0;
    logic signed [DATA_BITS-1:0] ring [WINDOW_MAX];
    logic [IDX_W-1:0]            ring_ptr    = '0;

    logic     pending_ticks[$];
    reading_t readings_due[$];
    reading_t want_reading;
    int       ticks_queued    = 0;
    int       ticks_taken     = 0;
    int       fail_count      = 0;
    int       send_pause      = 0;
    int       take_pause      = 0;
    int       recv_gap        = 0;
    int       quiet_cycles    = 0;
    bit       sender_pauses   = 1'b1;
    bit       receiver_pauses = 1'b1;

    load_cell_adc_reader dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // advances the model by one tick and returns what the block should report
    function automatic reading_t convert_tick(input logic dout);
        reading_t r;
        logic     period_up;
        int       len;
        int       k;
        longint   sum;
        longint   mean;
        longint   net_val;
        longint   prod;
        longint   grams;
        r = '0;
        if (tick_cnt != '1)
            tick_cnt = tick_cnt + 1'b1;
        period_up = tick_cnt > half_period;
        case (phase)
            SEQ_WAIT:
                if (!dout)
                begin
                    phase    = SEQ_FIRST_LOW;
                    tick_cnt = '0;
                end
            SEQ_FIRST_LOW:
                if (period_up)
                begin
                    sck_level = 1'b0;
                    phase     = SEQ_HIGH;
                    tick_cnt  = '0;
                end
            SEQ_HIGH:
                if (period_up)
                begin
                    sck_level = 1'b1;
                    phase     = SEQ_READ;
                    tick_cnt  = '0;
                end
            SEQ_READ:
                if (period_up)
                begin
                    shift_reg = {shift_reg[DATA_BITS-2:0], dout};
                    sck_level = 1'b0;
                    bits_in   = bits_in + 1'b1;
                    if (bits_in >= DATA_BITS)
                    begin
                        bits_in = '0;
                        phase   = SEQ_END_HIGH;
                    end
                    else
                        phase = SEQ_HIGH;
                    tick_cnt = '0;
                end
            SEQ_END_HIGH:
                if (period_up)
                begin
                    sck_level = 1'b1;
                    phase     = SEQ_END_LOW;
                    tick_cnt  = '0;
                end
            SEQ_END_LOW:
                // counter is left running here, the wait phase ignores it
                if (period_up)
                begin
                    sck_level = 1'b0;
                    phase     = SEQ_WAIT;
                    r.valid   = 1'b1;
                    r.raw     = shift_reg;
                    shift_reg = '0;
                end
            default:
                phase = SEQ_WAIT;
        endcase
        if (r.valid)
        begin
            len = (window_len == 0) ? 1 :
                  (window_len > WINDOW_MAX) ? WINDOW_MAX : int'(window_len);
            ring[ring_ptr] = r.raw;
            if (int'(ring_ptr) + 1 >= len)
                ring_ptr = '0;
            else
                ring_ptr = ring_ptr + 1'b1;
            // the mean always covers entries 0 to len-1, stale or not
            sum = 0;
            for (k = 0; k < len; k++)
                sum = sum + ring[k];
            mean    = sum / len;
            net_val = mean - tare;
            prod    = net_val * scale;
            grams   = prod / (longint'(1) << FRAC_BITS);
            if (grams > GRAMS_MAX)
                grams = GRAMS_MAX;
            if (grams < GRAMS_MIN)
                grams = GRAMS_MIN;
            r.avg     = mean[DATA_BITS-1:0];
            r.net_cnt = net_val[NET_W-1:0];
            r.weight  = grams[WEIGHT_W-1:0];
        end
        r.sck = sck_level;
        return r;
    endfunction

    function automatic int draw_pause(input bit enabled);
        return enabled ? int'($urandom_range(0, 16)) : 0;
    endfunction

    function automatic void compare_field(input string label, input logic [31:0] want,
                                          input logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %h actual %h", $time, label, want, got);
            fail_count++;
        end
    endfunction

    function automatic logic [DATA_BITS-1:0] pick_sample();
        logic [DATA_BITS-1:0] v;
        v = DATA_BITS'($urandom());
        case ($urandom_range(0, 7))
            0: v = 24'h800000;
            1: v = 24'h7FFFFF;
            2: v = 24'hFFFFFF;
            3: v = 24'h000000;
            4: v = v & 24'h0000FF;
            5: v = v | 24'hFFFF00;
            default: ;
        endcase
        return v;
    endfunction

    task automatic push_tick(input logic dout);
        pending_ticks.push_back(dout);
        ticks_queued++;
    endtask

    // one whole conversion from the wait phase, data bits placed on the read edges
    task automatic push_frame(input logic [DATA_BITS-1:0] value, input int lead_high);
        int e;
        int t;
        repeat (lead_high)
            push_tick(1'b1);
        push_tick(1'b0);
        for (e = 0; e < EDGES_PER_READ; e++)
        begin
            for (t = 0; t <= int'(half_period); t++)
            begin
                if (t == int'(half_period) && e >= 2 && e <= 48 && e % 2 == 0)
                    push_tick(value[24 - e / 2]);
                else
                    push_tick(1'($urandom_range(0, 1)));
            end
        end
    endtask

    // enough idle-high ticks to bring the sequencer back to its wait phase from anywhere
    task automatic push_resync();
        repeat ((EDGES_PER_READ + 1) * (int'(half_period) + 1))
            push_tick(1'b1);
    endtask

    task automatic wait_idle();
        while (ticks_taken != ticks_queued || readings_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [31:0] value);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        case (idx)
            REG_HALF_PERIOD: half_period = value[HALF_W-1:0];
            REG_WINDOW_LEN:  window_len  = value[WIN_W-1:0];
            REG_TARE:        tare        = value[DATA_BITS-1:0];
            REG_SCALE:       scale       = value;
            default: ;
        endcase
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // tick source
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid   <= 1'b0;
            s_tdata    <= '0;
            send_pause <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                readings_due.push_back(convert_tick(s_tdata[0]));
                ticks_taken++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (send_pause > 0)
                begin
                    s_tvalid   <= 1'b0;
                    send_pause <= send_pause - 1;
                end
                else if (pending_ticks.size() > 0)
                begin
                    s_tvalid   <= 1'b1;
                    s_tdata    <= {7'b0, pending_ticks.pop_front()};
                    send_pause <= draw_pause(sender_pauses);
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // result sink and checker
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready   <= 1'b0;
            take_pause <= 0;
        end
        else if (m_tvalid && m_tready)
        begin
            if (readings_due.size() == 0)
            begin
                $display("%0t: result with nothing expected, expected none actual %h/%b",
                         $time, m_tdata, m_tuser);
                fail_count++;
            end
            else
            begin
                want_reading = readings_due.pop_front();
                compare_field("sck", 32'(want_reading.sck), 32'(m_tdata[0]));
                compare_field("sample_valid", 32'(want_reading.valid), 32'(m_tuser));
                compare_field("raw_sample", 32'(want_reading.raw), 32'(m_tdata[24:1]));
                compare_field("average", 32'(want_reading.avg), 32'(m_tdata[48:25]));
                compare_field("net_count", 32'(want_reading.net_cnt), 32'(m_tdata[73:49]));
                compare_field("weight", want_reading.weight, m_tdata[105:74]);
                compare_field("tdata padding", 32'd0, 32'(m_tdata[111:106]));
            end
            recv_gap = draw_pause(receiver_pauses);
            m_tready   <= (recv_gap == 0);
            take_pause <= recv_gap;
        end
        else if (take_pause > 0)
        begin
            m_tready   <= (take_pause == 1);
            take_pause <= take_pause - 1;
        end
        else
            m_tready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        int          n;
        int          k;
        logic [31:0] cfg_value;
        foreach (ring[i])
            ring[i] = '0;
        repeat (5)
            @(posedge clk);
        rst_n <= 1'b1;

        // register defaults: half period setting of 10, clock rises on the 23rd tick
        push_tick(1'b0);
        repeat (24)
            push_tick(1'b1);
        wait_idle();
        write_reg(REG_HALF_PERIOD, 32'd0);
        push_resync();
        // default window of 3
        push_frame(24'h800000, 0);
        push_frame(24'hFFFFFF, 1);
        push_frame(24'h000000, 0);
        push_frame(24'h000001, 2);
        push_frame(24'h7FFFFF, 0);
        wait_idle();
        // zero length acts as a window of one
        write_reg(REG_WINDOW_LEN, 32'd0);
        push_frame(24'h123456, 0);
        wait_idle();
        // lengths past the ring size clamp to it
        write_reg(REG_WINDOW_LEN, 32'd31);
        push_frame(24'h800000, 0);
        push_frame(24'h800001, 0);
        wait_idle();
        write_reg(REG_WINDOW_LEN, 32'd16);
        push_frame(24'hFFFFFE, 0);
        wait_idle();
        write_reg(REG_WINDOW_LEN, 32'd1);
        write_reg(REG_TARE, 32'h0080_0000);
        write_reg(REG_SCALE, 32'h8000_0000);
        push_frame(24'h7FFFFF, 0);
        wait_idle();
        write_reg(REG_TARE, 32'h007F_FFFF);
        write_reg(REG_SCALE, 32'h7FFF_FFFF);
        push_frame(24'h800000, 0);
        wait_idle();

        // longest half period, then shortened while a read is under way
        sender_pauses   = 1'b0;
        receiver_pauses = 1'b0;
        write_reg(REG_HALF_PERIOD, 32'd1023);
        push_tick(1'b0);
        repeat (1030)
            push_tick(1'($urandom_range(0, 1)));
        wait_idle();
        write_reg(REG_HALF_PERIOD, 32'd1);
        push_resync();

        while (ticks_queued < 1950)
        begin
            wait_idle();
            sender_pauses   = ($urandom_range(0, 3) != 0);
            receiver_pauses = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 2) == 0)
            begin
                cfg_value = $urandom();
                cfg_value[HALF_W-1:0] = ($urandom_range(0, 9) < 7) ? HALF_W'(0)
                                                                   : HALF_W'($urandom_range(1, 3));
                write_reg(REG_HALF_PERIOD, cfg_value);
            end
            if ($urandom_range(0, 2) == 0)
                write_reg(REG_WINDOW_LEN, $urandom_range(0, 1) ? $urandom_range(1, 16)
                                                                : $urandom_range(0, 31));
            if ($urandom_range(0, 3) == 0)
                write_reg(REG_TARE, $urandom());
            if ($urandom_range(0, 3) == 0)
                write_reg(REG_SCALE, $urandom());
            n = $urandom_range(1, 4);
            for (k = 0; k < n; k++)
                push_frame(pick_sample(), $urandom_range(0, 4));
            // now and then a burst of pin noise, which can leave a read half done
            if ($urandom_range(0, 3) == 0)
            begin
                n = $urandom_range(10, 60);
                for (k = 0; k < n; k++)
                    push_tick(1'($urandom_range(0, 1)));
                push_resync();
            end
        end

        wait_idle();
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

[sim.f]
design/lcar_pkg.sv
design/lcar_serial.sv
design/lcar_ring.sv
design/lcar_div.sv
design/load_cell_adc_reader.sv
sim/tb_load_cell_adc_reader.sv
